[rtl/core/rcd_pkg.sv]
`timescale 1ns / 1ps
// ============================================================================
// rcd_pkg: shared definitions for the range cache directory
// Holds the default sizes, field widths, reset values and the codes of the
// item command and of the configuration register indexes.
// ============================================================================
package rcd_pkg;

    localparam int DEF_SMALL_DEPTH = 16;
    localparam int DEF_LARGE_DEPTH = 16;
    localparam int DEF_OFFSET_BITS = 48;

    localparam int LEN_BITS  = 32;
    localparam int CAP_BITS  = 5;
    localparam int CFG_IDX_W = 2;

    localparam logic [LEN_BITS-1:0] RST_SMALL_LIMIT = 32'd65536;
    localparam logic [CAP_BITS-1:0] RST_SMALL_CAP   = 5'd16;
    localparam logic [CAP_BITS-1:0] RST_LARGE_CAP   = 5'd16;

    typedef enum logic {
        CMD_LOOKUP = 1'b0,
        CMD_INSERT = 1'b1
    } cmd_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SMALL_LIMIT = 2'd0,
        CFG_SMALL_CAP   = 2'd1,
        CFG_LARGE_CAP   = 2'd2
    } cfg_index_t;

endpackage

[rtl/core/two_tier_range_cache_directory.sv]
`timescale 1ns / 1ps
// ============================================================================
// two_tier_range_cache_directory: byte-range cache directory, two FIFO tiers
// A lookup item passes the input register, then the result register, where
// its result waits until taken. Throughput: 1 item per cycle unless a lookup
// waits for the result register; every held entry of a tier is compared in
// parallel, and an insert updates the tier as the item leaves the input stage.
// Inserts give no result. Reset (aresetn low, synchronous) empties both
// tiers and restores the limit to 65536 and both capacities to 16.
// ============================================================================
module two_tier_range_cache_directory
    import rcd_pkg::*;
#(
    parameter int SMALL_DEPTH = DEF_SMALL_DEPTH,
    parameter int LARGE_DEPTH = DEF_LARGE_DEPTH,
    parameter int OFFSET_BITS = DEF_OFFSET_BITS,
    parameter int SLOT_BITS   = ((SMALL_DEPTH > LARGE_DEPTH ? SMALL_DEPTH : LARGE_DEPTH) > 1)
                              ? $clog2(SMALL_DEPTH > LARGE_DEPTH ? SMALL_DEPTH : LARGE_DEPTH)
                              : 1,
    parameter int S_DATA_W    = ((OFFSET_BITS + LEN_BITS + 7) / 8) * 8,
    parameter int M_DATA_W    = ((SLOT_BITS + 2 * LEN_BITS + 7) / 8) * 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // configuration write port
    input  logic                 cfg_wen,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [LEN_BITS-1:0]  cfg_wdata,
    // input items
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_DATA_W-1:0]  s_tdata,   // range_start, range_length, zero pad
    input  logic [0:0]           s_tuser,   // command
    // result items
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_DATA_W-1:0]  m_tdata,   // slot, start_within, fetch_length, zero pad
    output logic [1:0]           m_tuser    // hit, from_large
);

    localparam int SMALL_IDX_W = (SMALL_DEPTH > 1) ? $clog2(SMALL_DEPTH) : 1;
    localparam int LARGE_IDX_W = (LARGE_DEPTH > 1) ? $clog2(LARGE_DEPTH) : 1;
    localparam int PAD_W       = M_DATA_W - SLOT_BITS - 2 * LEN_BITS;

    // configuration registers
    logic [LEN_BITS-1:0]    limit_reg;
    logic [CAP_BITS-1:0]    small_cap_reg, large_cap_reg;

    // input stage
    logic                   in_valid_reg;
    cmd_t                   in_cmd_reg;
    logic [OFFSET_BITS-1:0] in_start_reg;
    logic [LEN_BITS-1:0]    in_len_reg;

    // result stage
    logic                   out_valid_reg;
    logic                   out_hit_reg, out_large_reg;
    logic [SLOT_BITS-1:0]   out_slot_reg;
    logic [LEN_BITS-1:0]    out_within_reg, out_fetch_reg;

    logic                   out_free, advance, is_large, is_lookup;
    logic                   small_ins, large_ins;
    logic                   small_hit, large_hit, sel_hit;
    logic [SMALL_IDX_W-1:0] small_slot;
    logic [LARGE_IDX_W-1:0] large_slot;
    logic [LEN_BITS-1:0]    small_within, large_within;
    logic [SLOT_BITS-1:0]   sel_slot;
    logic [LEN_BITS-1:0]    sel_within, fetch_len;

    // ---------------- configuration ----------------
    // Hold each register until a write names it; drop writes to unknown indexes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg     <= RST_SMALL_LIMIT;
            small_cap_reg <= RST_SMALL_CAP;
            large_cap_reg <= RST_LARGE_CAP;
        end else if (cfg_wen) begin
            case (cfg_index)
                CFG_SMALL_LIMIT: limit_reg     <= cfg_wdata;
                CFG_SMALL_CAP:   small_cap_reg <= cfg_wdata[CAP_BITS-1:0];
                CFG_LARGE_CAP:   large_cap_reg <= cfg_wdata[CAP_BITS-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- handshake ----------------
    // An insert leaves the input stage freely; a lookup needs a free result
    // register (empty, or being taken this cycle).
    assign is_lookup = (in_cmd_reg == CMD_LOOKUP);
    assign out_free  = !out_valid_reg || m_tready;
    assign advance   = in_valid_reg && (!is_lookup || out_free);
    assign s_tready  = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_cmd_reg   <= cmd_t'(s_tuser[0]);
            in_start_reg <= s_tdata[OFFSET_BITS-1:0];
            in_len_reg   <= s_tdata[OFFSET_BITS +: LEN_BITS];
        end
    end

    // ---------------- tier choice ----------------
    // Lengths above the limit belong to the large tier, for inserts and lookups.
    assign is_large  = in_len_reg > limit_reg;
    assign fetch_len = is_large ? in_len_reg : limit_reg;
    assign small_ins = advance && !is_lookup && !is_large;
    assign large_ins = advance && !is_lookup && is_large;

    rcd_tier #(
        .DEPTH       (SMALL_DEPTH),
        .OFFSET_BITS (OFFSET_BITS),
        .IDX_W       (SMALL_IDX_W)
    ) u_small (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ins_en   (small_ins),
        .capacity (small_cap_reg),
        .q_start  (in_start_reg),
        .q_length (in_len_reg),
        .q_hit    (small_hit),
        .q_slot   (small_slot),
        .q_within (small_within)
    );

    rcd_tier #(
        .DEPTH       (LARGE_DEPTH),
        .OFFSET_BITS (OFFSET_BITS),
        .IDX_W       (LARGE_IDX_W)
    ) u_large (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ins_en   (large_ins),
        .capacity (large_cap_reg),
        .q_start  (in_start_reg),
        .q_length (in_len_reg),
        .q_hit    (large_hit),
        .q_slot   (large_slot),
        .q_within (large_within)
    );

    // Pick the searched tier; zero slot and offset on a miss.
    always_comb begin
        sel_hit    = is_large ? large_hit : small_hit;
        sel_slot   = '0;
        sel_within = '0;
        if (sel_hit) begin
            sel_slot   = is_large ? SLOT_BITS'(large_slot) : SLOT_BITS'(small_slot);
            sel_within = is_large ? large_within : small_within;
        end
    end

    // ---------------- result register ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= advance && is_lookup;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free && advance && is_lookup) begin
            out_hit_reg    <= sel_hit;
            out_large_reg  <= is_large;
            out_slot_reg   <= sel_slot;
            out_within_reg <= sel_within;
            out_fetch_reg  <= fetch_len;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = {out_large_reg, out_hit_reg};
    assign m_tdata  = {PAD_W'(0), out_fetch_reg, out_within_reg, out_slot_reg};

    // ---------------- checks ----------------
    a_insert_no_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_free && advance && !is_lookup) |=> !out_valid_reg)
        else $error("insert item produced a result");

    a_stall_holds_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !advance) |=> (in_valid_reg && $stable(in_start_reg)
                                        && $stable(in_len_reg)))
        else $error("stalled item lost from input stage");

    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("waiting result item changed");

endmodule

[rtl/core/rcd_tier.sv]
`timescale 1ns / 1ps
// ============================================================================
// rcd_tier: one FIFO tier of the directory
// Ring store of ranges with head and count. Takes one insert per cycle and
// answers a containment query against every held entry in parallel, oldest
// matching entry first.
// ============================================================================
module rcd_tier
    import rcd_pkg::*;
#(
    parameter int DEPTH       = DEF_SMALL_DEPTH,
    parameter int OFFSET_BITS = DEF_OFFSET_BITS,
    parameter int IDX_W       = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   ins_en,
    input  logic [CAP_BITS-1:0]    capacity,
    input  logic [OFFSET_BITS-1:0] q_start,
    input  logic [LEN_BITS-1:0]    q_length,
    output logic                   q_hit,
    output logic [IDX_W-1:0]       q_slot,
    output logic [LEN_BITS-1:0]    q_within
);

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int EW    = (CNT_W > CAP_BITS) ? CNT_W : CAP_BITS;
    localparam int SUM_W = OFFSET_BITS + 1;

    logic [OFFSET_BITS-1:0] starts_reg  [DEPTH];
    logic [LEN_BITS-1:0]    lengths_reg [DEPTH];
    logic [IDX_W-1:0]       head_reg, head_next;
    logic [CNT_W-1:0]       count_reg, count_next;

    logic [EW-1:0]          eff_cap, count_ext;
    logic [CNT_W:0]         pos_sum;
    logic [IDX_W-1:0]       wr_pos, head_inc;

    logic [DEPTH-1:0]       match;
    logic [DEPTH-1:0]       upper;
    logic [LEN_BITS-1:0]    within_arr [DEPTH];
    logic [IDX_W-1:0]       sel;

    // ---------------- insert ----------------
    always_comb begin
        eff_cap   = (EW'(capacity) < EW'(DEPTH)) ? EW'(capacity) : EW'(DEPTH);
        count_ext = EW'(count_reg);
        pos_sum   = (CNT_W + 1)'(head_reg) + (CNT_W + 1)'(count_reg);
        if (pos_sum >= (CNT_W + 1)'(DEPTH)) begin
            pos_sum = pos_sum - (CNT_W + 1)'(DEPTH);
        end
        wr_pos   = IDX_W'(pos_sum);
        head_inc = (head_reg == IDX_W'(DEPTH - 1)) ? '0 : head_reg + 1'b1;

        head_next  = head_reg;
        count_next = count_reg;
        if (ins_en) begin
            // full ring or at capacity: new entry pushes the oldest out
            if (count_reg == CNT_W'(DEPTH) || count_ext >= eff_cap) begin
                head_next = head_inc;
            end else begin
                count_next = count_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= '0;
            count_reg <= '0;
        end else begin
            head_reg  <= head_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ins_en) begin
            starts_reg[wr_pos]  <= q_start;
            lengths_reg[wr_pos] <= q_length;
        end
    end

    // ---------------- lookup ----------------
    always_comb begin
        logic [CNT_W-1:0] rel;
        logic             contain;
        for (int i = 0; i < DEPTH; i++) begin
            upper[i] = (IDX_W'(i) >= head_reg);
            if (upper[i]) begin
                rel = CNT_W'(i) - CNT_W'(head_reg);
            end else begin
                rel = CNT_W'(i + DEPTH) - CNT_W'(head_reg);
            end
            contain = (starts_reg[i] <= q_start) &&
                      ((SUM_W'(q_start) + SUM_W'(q_length)) <=
                       (SUM_W'(starts_reg[i]) + SUM_W'(lengths_reg[i])));
            match[i]      = (rel < count_reg) && contain;
            within_arr[i] = LEN_BITS'(q_start - starts_reg[i]);
        end
    end

    // oldest match: lowest slot at or after head, else lowest slot overall
    always_comb begin
        sel = '0;
        for (int i = DEPTH - 1; i >= 0; i--) begin
            if (match[i]) begin
                sel = IDX_W'(i);
            end
        end
        for (int i = DEPTH - 1; i >= 0; i--) begin
            if (match[i] && upper[i]) begin
                sel = IDX_W'(i);
            end
        end
    end

    assign q_hit    = |match;
    assign q_slot   = sel;
    assign q_within = within_arr[sel];

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("tier count above depth");

    a_insert_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        (ins_en && count_ext < eff_cap && count_reg != CNT_W'(DEPTH)) |=>
            (count_reg == $past(count_reg) + 1'b1) && (head_reg == $past(head_reg)))
        else $error("insert below capacity did not grow the tier");

    a_empty_no_hit: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == '0) |-> !q_hit)
        else $error("empty tier reported a hit");

endmodule

[bench/testbench.sv]
`timescale 1ns / 1ps
// ============================================================================
// testbench: self-checking bench for two_tier_range_cache_directory
// Drives insert and lookup items into the range directory, mirrors both FIFO
// tiers in a local scoreboard model and compares each lookup result field by
// field. Opens with a short directed table, then runs randomized phases under
// several register settings, with random gaps on both streams and one long
// stall of the result side.
// ============================================================================
module testbench;
    import rcd_pkg::*;

    localparam int TIER_DEPTH   = 16;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int HOLD_CYCLES  = 400;
    localparam int SETTLE_CYCLES = 8;
    localparam int POOL_MAX     = 48;

    // one lookup result as the directory reports it
    typedef struct packed {
        logic        hit;
        logic        from_large;
        logic [3:0]  slot;
        logic [31:0] start_off;
        logic [31:0] fetch;
    } lookup_result_t;

    typedef struct {
        cmd_t           cmd;
        logic [47:0]    start;
        logic [31:0]    len;
        bit             typed;
        lookup_result_t res;
    } stim_row_t;

    typedef struct {
        logic [47:0] start;
        logic [31:0] len;
    } span_t;

    logic         aclk;
    logic         aresetn;
    logic         cfg_wen;
    cfg_index_t   cfg_index;
    logic [31:0]  cfg_wdata;
    logic         s_tvalid;
    logic         s_tready;
    logic [79:0]  s_tdata;   // range_start [47:0], range_length [79:48]
    logic [0:0]   s_tuser;   // command
    logic         m_tvalid;
    logic         m_tready;
    logic [71:0]  m_tdata;   // slot [3:0], start_within [35:4], fetch_length [67:36], pad
    logic [1:0]   m_tuser;   // hit [0], from_large [1]

    two_tier_range_cache_directory u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    // ------------------------------------------------------------------------
    // Scoreboard copy of the directory: tier 0 is small, tier 1 is large.
    // ------------------------------------------------------------------------
    logic [47:0] tier_start [2][TIER_DEPTH];
    logic [31:0] tier_len   [2][TIER_DEPTH];
    int unsigned tier_head  [2];
    int unsigned tier_count [2];
    int unsigned tier_cap   [2];
    logic [31:0] size_limit;

    lookup_result_t pending_lookups[$];   // results still owed by the block
    span_t          inserted_spans[$];    // recent inserts, to aim lookups at
    int unsigned    mismatch_count;
    int unsigned    cycle_count;
    bit             hold_off_req;
    bit             send_steady;
    bit             recv_steady;

    // Advance the model by one accepted item; return the result a lookup owes.
    function automatic bit model_item(input cmd_t cmd, input logic [47:0] start,
                                      input logic [31:0] len,
                                      output lookup_result_t res);
        int unsigned t;
        int unsigned eff;
        int unsigned pos;
        logic [63:0] es;
        logic [63:0] ee;
        t = (len > size_limit) ? 1 : 0;
        res = '0;
        if (cmd == CMD_INSERT) begin
            eff = (tier_cap[t] < TIER_DEPTH) ? tier_cap[t] : TIER_DEPTH;
            pos = (tier_head[t] + tier_count[t]) % TIER_DEPTH;
            tier_start[t][pos] = start;
            tier_len[t][pos]   = len;
            if (tier_count[t] < TIER_DEPTH) begin
                tier_count[t]++;
                if (tier_count[t] > eff) begin
                    tier_head[t] = (tier_head[t] + 1) % TIER_DEPTH;
                    tier_count[t]--;
                end
            end else begin
                // ring full: the new entry took the oldest slot, drop it
                tier_head[t] = (tier_head[t] + 1) % TIER_DEPTH;
            end
            return 1'b0;
        end
        res.from_large = t[0];
        res.fetch      = (len > size_limit) ? len : size_limit;
        // scan from oldest to newest, first containing entry wins
        for (int i = 0; i < tier_count[t]; i++) begin
            pos = (tier_head[t] + i) % TIER_DEPTH;
            es  = {16'd0, tier_start[t][pos]};
            ee  = es + {32'd0, tier_len[t][pos]};
            if (es <= {16'd0, start} && {16'd0, start} + {32'd0, len} <= ee) begin
                res.hit       = 1'b1;
                res.slot      = pos[3:0];
                res.start_off = 32'(start - tier_start[t][pos]);
                break;
            end
        end
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------------
    // Clock, reset and cycle guard
    // ------------------------------------------------------------------------
    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("two_tier_range_cache_directory verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Result checker: compare each accepted result with the oldest owed one.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        lookup_result_t exp_res;
        lookup_result_t got_res;
        if (aresetn && m_tvalid && m_tready) begin
            got_res = '{m_tuser[0], m_tuser[1], m_tdata[3:0], m_tdata[35:4],
                        m_tdata[67:36]};
            if (pending_lookups.size() == 0) begin
                mismatch_count++;
                $display("%0t: unexpected result, expected none,", $time,
                         " actual hit=%0b large=%0b slot=%0d within=%h fetch=%h",
                         got_res.hit, got_res.from_large, got_res.slot,
                         got_res.start_off, got_res.fetch);
            end else begin
                exp_res = pending_lookups.pop_front();
                if (got_res !== exp_res) begin
                    mismatch_count++;
                    $display("%0t: result mismatch expected hit=%0b large=%0b", $time,
                             exp_res.hit, exp_res.from_large,
                             " slot=%0d within=%h fetch=%h,", exp_res.slot,
                             exp_res.start_off, exp_res.fetch,
                             " actual hit=%0b large=%0b", got_res.hit,
                             got_res.from_large,
                             " slot=%0d within=%h fetch=%h", got_res.slot,
                             got_res.start_off, got_res.fetch);
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result side: random stall before each item, steady stretches, and one
    // long hold-off on request so the block backs up into its input.
    // ------------------------------------------------------------------------
    initial begin
        int unsigned stall;
        m_tready = 1'b0;
        forever begin
            if (hold_off_req) begin
                m_tready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_off_req = 1'b0;
            end
            if ($urandom_range(0, 39) == 0)
                recv_steady = ~recv_steady;
            stall = recv_steady ? 0 : $urandom_range(0, 15);
            if (stall > 0) begin
                m_tready = 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready = 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            @(negedge aclk);
        end
    end

    // ------------------------------------------------------------------------
    // Input side helpers; every task starts and ends on a falling edge.
    // ------------------------------------------------------------------------
    task automatic push_item(input cmd_t cmd, input logic [47:0] start,
                             input logic [31:0] len, input bit typed,
                             input lookup_result_t typed_res);
        int unsigned gap;
        lookup_result_t res;
        span_t span;
        if ($urandom_range(0, 39) == 0)
            send_steady = ~send_steady;
        gap = send_steady ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tuser  = cmd;
        s_tdata  = {len, start};
        do @(posedge aclk); while (!s_tready);
        // item taken at this edge: advance the model and log what is owed
        if (model_item(cmd, start, len, res))
            pending_lookups.insert(pending_lookups.size(), typed ? typed_res : res);
        if (cmd == CMD_INSERT) begin
            span.start = start;
            span.len   = len;
            inserted_spans.insert(inserted_spans.size(), span);
            if (inserted_spans.size() > POOL_MAX)
                void'(inserted_spans.pop_front());
        end
        @(negedge aclk);
    endtask

    // Hold until every owed result is back and inserts have settled.
    task automatic drain_block();
        s_tvalid = 1'b0;
        while (pending_lookups.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic program_tiers(input logic [31:0] limit, input logic [4:0] small_cap,
                                 input logic [4:0] large_cap);
        drain_block();
        cfg_wen   = 1'b1;
        cfg_index = CFG_SMALL_LIMIT;
        cfg_wdata = limit;
        size_limit = limit;
        @(negedge aclk);
        cfg_index = CFG_SMALL_CAP;
        cfg_wdata = {27'd0, small_cap};
        tier_cap[0] = small_cap;
        @(negedge aclk);
        cfg_index = CFG_LARGE_CAP;
        cfg_wdata = {27'd0, large_cap};
        tier_cap[1] = large_cap;
        @(negedge aclk);
        cfg_wen = 1'b0;
        @(negedge aclk);
    endtask

    function automatic logic [31:0] pick_length();
        case ($urandom_range(0, 9))
            0:       return 32'd0;
            1:       return 32'hFFFF_FFFF;
            2:       return $urandom;
            3:       return size_limit;
            4:       return size_limit + 32'd1;
            8, 9:    return size_limit + $urandom_range(1, 1 << 20);
            default: return $urandom_range(1, 4096);
        endcase
    endfunction

    function automatic logic [47:0] pick_start();
        logic [47:0] base;
        case ($urandom_range(0, 5))
            0:       return {16'($urandom_range(0, 16'hFFFF)), $urandom};
            1:       return 48'hFFFF_FFFF_FFFF - $urandom_range(0, 1 << 16);
            2:       base = 48'h0000_4000_0000;
            3:       base = 48'hFFFF_F000_0000;
            default: base = 48'h0;
        endcase
        return base + $urandom_range(0, 1 << 18);
    endfunction

    // Random inserts and lookups; most lookups are aimed inside recent inserts.
    task automatic push_random();
        span_t       target;
        logic [47:0] start;
        logic [31:0] len;
        logic [31:0] off;
        if ($urandom_range(0, 99) < 45) begin
            push_item(CMD_INSERT, pick_start(), pick_length(), 1'b0, '0);
        end else if (inserted_spans.size() != 0 && $urandom_range(0, 99) < 65) begin
            target = inserted_spans[$urandom_range(0, inserted_spans.size() - 1)];
            off    = $urandom_range(0, target.len);
            start  = target.start + off;
            len    = $urandom_range(0, target.len - off);
            // nudge a few just past an edge of the entry
            case ($urandom_range(0, 7))
                0:       len   = len + 32'd1;
                1:       start = start - 48'd1;
                default: ;
            endcase
            push_item(CMD_LOOKUP, start, len, 1'b0, '0);
        end else begin
            push_item(CMD_LOOKUP, pick_start(), pick_length(), 1'b0, '0);
        end
    endtask

    // ------------------------------------------------------------------------
    // Directed rows: typed results are read straight off the reset settings
    // (limit 65536, both capacities 16); the rest go through the model.
    // ------------------------------------------------------------------------
    stim_row_t directed_rows [23];

    initial begin
        directed_rows = '{
            // empty directory: every lookup misses, both tiers
            '{CMD_LOOKUP, 48'h0,              32'h0,         1'b1,
              '{1'b0, 1'b0, 4'd0, 32'h0,   32'h0001_0000}},
            '{CMD_LOOKUP, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
              '{1'b0, 1'b1, 4'd0, 32'h0,   32'hFFFF_FFFF}},
            '{CMD_INSERT, 48'h1000,           32'h100,       1'b0, '0},
            '{CMD_LOOKUP, 48'h1010,           32'h10,        1'b1,
              '{1'b1, 1'b0, 4'd0, 32'h10,  32'h0001_0000}},
            '{CMD_LOOKUP, 48'h1000,           32'h100,       1'b1,
              '{1'b1, 1'b0, 4'd0, 32'h0,   32'h0001_0000}},
            // one byte past the end of the entry
            '{CMD_LOOKUP, 48'h1000,           32'h101,       1'b1,
              '{1'b0, 1'b0, 4'd0, 32'h0,   32'h0001_0000}},
            // empty range at the end of the span is still contained
            '{CMD_LOOKUP, 48'h1100,           32'h0,         1'b1,
              '{1'b1, 1'b0, 4'd0, 32'h100, 32'h0001_0000}},
            '{CMD_LOOKUP, 48'h0FFF,           32'h2,         1'b1,
              '{1'b0, 1'b0, 4'd0, 32'h0,   32'h0001_0000}},
            '{CMD_INSERT, 48'hFFFF_0000_0000, 32'hFFFF_FFFF, 1'b0, '0},
            // length equal to the limit picks the small tier
            '{CMD_LOOKUP, 48'hFFFF_0000_0005, 32'h0001_0000, 1'b1,
              '{1'b0, 1'b0, 4'd0, 32'h0,   32'h0001_0000}},
            '{CMD_LOOKUP, 48'hFFFF_0000_0005, 32'h0001_0001, 1'b1,
              '{1'b1, 1'b1, 4'd0, 32'h5,   32'h0001_0001}},
            // entry reaching past the top of the offset space
            '{CMD_INSERT, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF, 1'b0, '0},
            '{CMD_LOOKUP, 48'hFFFF_FFFF_FFFF, 32'h0002_0000, 1'b0, '0},
            // overlapping entries: the oldest containing one wins
            '{CMD_INSERT, 48'h1000,           32'h200,       1'b0, '0},
            '{CMD_LOOKUP, 48'h1050,           32'h20,        1'b0, '0},
            '{CMD_LOOKUP, 48'h1150,           32'h20,        1'b0, '0},
            '{CMD_INSERT, 48'h5000,           32'h0,         1'b0, '0},
            '{CMD_LOOKUP, 48'h5000,           32'h0,         1'b0, '0},
            '{CMD_LOOKUP, 48'h1000,           32'h0001_0000, 1'b0, '0},
            '{CMD_INSERT, 48'h0,              32'h0001_0000, 1'b0, '0},
            '{CMD_LOOKUP, 48'h0,              32'h1,         1'b0, '0},
            '{CMD_INSERT, 48'hAAAA_5555_AAAA, 32'h5555_AAAA, 1'b0, '0},
            '{CMD_LOOKUP, 48'hAAAA_5555_AAAB, 32'h5555_0000, 1'b0, '0}
        };
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        aresetn   = 1'b0;
        cfg_wen   = 1'b0;
        cfg_index = CFG_SMALL_LIMIT;
        cfg_wdata = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = CMD_LOOKUP;
        hold_off_req   = 1'b0;
        send_steady    = 1'b0;
        recv_steady    = 1'b0;
        mismatch_count = 0;
        cycle_count    = 0;
        // model state after reset
        size_limit = RST_SMALL_LIMIT;
        tier_cap[0] = RST_SMALL_CAP;
        tier_cap[1] = RST_LARGE_CAP;
        for (int t = 0; t < 2; t++) begin
            tier_head[t]  = 0;
            tier_count[t] = 0;
        end

        repeat (10) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        foreach (directed_rows[i])
            push_item(directed_rows[i].cmd, directed_rows[i].start, directed_rows[i].len,
                      directed_rows[i].typed, directed_rows[i].res);

        // reset settings: overrun both rings so the oldest slot is overwritten
        repeat (230) push_random();

        // capacities lowered below the held count: each insert drops the oldest entry
        program_tiers(32'd1000, 5'd3, 5'd5);
        repeat (200) push_random();

        // limit zero: only empty ranges are small, and that tier keeps nothing;
        // large capacity above the ring depth
        program_tiers(32'd0, 5'd0, 5'd31);
        repeat (150) push_random();

        // limit at its top: everything small, so the large tier sees no items;
        // stall the result side for a long stretch while items keep coming
        program_tiers(32'hFFFF_FFFF, 5'd31, 5'd0);
        hold_off_req = 1'b1;
        send_steady  = 1'b1;
        repeat (200) push_random();

        program_tiers($urandom, 5'($urandom_range(1, 16)), 5'($urandom_range(1, 16)));
        repeat (200) push_random();

        // back to the reset settings
        program_tiers(RST_SMALL_LIMIT, RST_SMALL_CAP, RST_LARGE_CAP);
        repeat (200) push_random();

        // wait out the last results and the pipeline tail
        drain_block();
        repeat (10) @(posedge aclk);
        if (mismatch_count == 0)
            $display("two_tier_range_cache_directory verification clean");
        else
            $display("two_tier_range_cache_directory verification failed");
        $finish;
    end

endmodule

[filelist.f]
rtl/core/rcd_pkg.sv
rtl/core/rcd_tier.sv
rtl/core/two_tier_range_cache_directory.sv
bench/testbench.sv
